[src/button_debounce_press_classifier_assert.svh]
// Assertion macros used by the checker file of the press classifier.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// Checked at every rising edge of clk, suspended while rst is high.
`define BDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define BDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bdpc_pkg.sv]
// Package for the button debounce press classifier: constants and types.
`timescale 1ns / 1ps
package bdpc_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int BTN_W       = 1;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int EVENT_W     = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic              last_level;
    logic              stable_level;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic              long_done;
  } btn_state_t;

endpackage

[src/button_debounce_press_classifier.sv]
// Button debounce and short/long press classifier, top level.
`timescale 1ns / 1ps
// Takes one sample per transfer (button index, raw pressed level, ms timestamp)
// and returns one press_event per sample: none, short press or long press.
// Samples pass an input register, then the per-button state is read, updated
// and the event registered; a sample is taken every cycle unless the output
// stalls. A sample for the same button right behind another sees the updated
// state. The user must write debounce_time and long_press_time through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module button_debounce_press_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdpc_pkg::BTN_W-1:0]        button_index,
  input  logic                              raw_pressed,
  input  logic [bdpc_pkg::TIME_W-1:0]       now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bdpc_pkg::EVENT_W-1:0]      press_event,
  input  logic                              cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdpc_pkg::CFG_W-1:0]        cfg_data
);
  import bdpc_pkg::*;

  logic [CFG_W-1:0]  debounce_time;
  logic [CFG_W-1:0]  long_press_time;
  btn_state_t        btn_state [NUM_BUTTONS];

  logic              s1_valid;
  logic [BTN_W-1:0]  s1_button;
  logic              s1_raw;
  logic [TIME_W-1:0] s1_now;

  logic              out_free;
  logic              advance;
  logic              s1_in_range;
  btn_state_t        cur;
  btn_state_t        nxt;
  logic [EVENT_W-1:0] eval_event;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  assign s1_in_range = ({{(32-BTN_W){1'b0}}, s1_button} < 32'(NUM_BUTTONS));
  assign cur = btn_state[s1_button];

  bdpc_eval u_eval (
    .cur             (cur),
    .raw_pressed     (s1_raw),
    .now_ms          (s1_now),
    .debounce_time   (debounce_time),
    .long_press_time (long_press_time),
    .nxt             (nxt),
    .press_event     (eval_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_data;
        REG_LONG_PRESS: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_button <= button_index;
      s1_raw    <= raw_pressed;
      s1_now    <= now_ms;
    end
  end

  // per-button state, written as the sample moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_state[i] <= '0;
      end
    end else if (advance && s1_in_range) begin
      btn_state[s1_button] <= nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_event <= s1_in_range ? eval_event : EV_NONE;
    end
  end

endmodule

[src/bdpc_eval.sv]
// Next-state and event logic for one button sample.
`timescale 1ns / 1ps
module bdpc_eval (
  input  bdpc_pkg::btn_state_t            cur,
  input  logic                            raw_pressed,
  input  logic [bdpc_pkg::TIME_W-1:0]     now_ms,
  input  logic [bdpc_pkg::CFG_W-1:0]      debounce_time,
  input  logic [bdpc_pkg::CFG_W-1:0]      long_press_time,
  output bdpc_pkg::btn_state_t            nxt,
  output logic [bdpc_pkg::EVENT_W-1:0]    press_event
);
  import bdpc_pkg::*;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic              db_done;
  logic              lp_done;

  // signed wrap: a negative difference means not yet elapsed
  assign since_change = now_ms - cur.change_time;
  assign since_press  = now_ms - cur.press_time;
  assign db_done = !since_change[TIME_W-1] &&
                   (since_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
  assign lp_done = !since_press[TIME_W-1] &&
                   (since_press >= {{(TIME_W-CFG_W){1'b0}}, long_press_time});

  always_comb begin
    nxt         = cur;
    press_event = EV_NONE;
    priority if (raw_pressed != cur.last_level) begin
      nxt.last_level  = raw_pressed;
      nxt.change_time = now_ms;
    end else if (db_done) begin
      priority if (raw_pressed && !cur.stable_level) begin
        nxt.stable_level = 1'b1;
        nxt.press_time   = now_ms;
        nxt.long_done    = 1'b0;
      end else if (!raw_pressed && cur.stable_level) begin
        nxt.stable_level = 1'b0;
        if (!cur.long_done) begin
          press_event = EV_SHORT;
        end
      end else if (raw_pressed && cur.stable_level && !cur.long_done && lp_done) begin
        nxt.long_done = 1'b1;
        press_event   = EV_LONG;
      end else begin
        // stable level already matches, long press spent or not yet due
      end
    end else begin
      // level steady, debounce still running
    end
  end

endmodule

[src/bdpc_checker.sv]
// Port-level checker for the press classifier, bound to the top level.
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_assert.svh"
module bdpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bdpc_pkg::EVENT_W-1:0]      press_event
);
  import bdpc_pkg::*;

  logic in_xfer;
  logic out_wait;

  assign in_xfer  = in_valid && !in_stall;
  assign out_wait = out_valid && out_stall;

  `BDPC_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(press_event), "stalled result changed")
  `BDPC_ASSERT(a_event_code, out_valid |-> press_event <= EV_LONG, "undefined press_event code")
  `BDPC_ASSERT(a_latency, in_xfer ##1 !out_stall |=> out_valid, "sample transfer lost")
  `BDPC_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);

[tb/tb_button_debounce_press_classifier.sv]
// Self-checking testbench for the button debounce press classifier.
`timescale 1ns / 1ps
module tb_button_debounce_press_classifier;
  import bdpc_pkg::*;

  // Predicts the press event of every accepted sample and checks the events in order.
  class press_scoreboard;
    btn_state_t         btn_st [NUM_BUTTONS];
    logic [CFG_W-1:0]   db_time;
    logic [CFG_W-1:0]   long_ms;
    logic [EVENT_W-1:0] pending_events [$];
    int                 errors;

    function new();
      db_time     = DEBOUNCE_RESET;
      long_ms     = LONG_PRESS_RESET;
      errors      = 0;
      foreach (btn_st[i]) btn_st[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_DEBOUNCE) db_time = val;
      else if (idx == REG_LONG_PRESS) long_ms = val;
    endfunction

    // signed 32-bit difference now - since, compared against limit; negative = not yet
    function bit held_for(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since,
                          logic [CFG_W-1:0] limit);
      logic [TIME_W-1:0] d;
      d = now - since;
      if (d[TIME_W-1]) return 1'b0;
      return d >= TIME_W'(limit);
    endfunction

    function void note_sample(logic [BTN_W-1:0] b, logic raw, logic [TIME_W-1:0] now);
      btn_state_t         st;
      logic [EVENT_W-1:0] evt;
      evt = EV_NONE;
      if (int'(b) < NUM_BUTTONS) begin
        st = btn_st[b];
        if (raw != st.last_level) begin
          st.last_level  = raw;
          st.change_time = now;
        end else if (held_for(now, st.change_time, db_time)) begin
          if (raw && !st.stable_level) begin
            st.stable_level = 1'b1;
            st.press_time   = now;
            st.long_done    = 1'b0;
          end else if (!raw && st.stable_level) begin
            st.stable_level = 1'b0;
            if (!st.long_done) evt = EV_SHORT;
          end else if (raw && st.stable_level && !st.long_done) begin
            if (held_for(now, st.press_time, long_ms)) begin
              st.long_done = 1'b1;
              evt = EV_LONG;
            end
          end
        end
        btn_st[b] = st;
      end
      pending_events.push_back(evt);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_event(logic [EVENT_W-1:0] got);
      logic [EVENT_W-1:0] want;
      if (pending_events.size() == 0) begin
        report($sformatf("press_event %0d with no sample outstanding", got));
      end else begin
        want = pending_events.pop_front();
        if (got !== want)
          report($sformatf("press_event got %0d, want %0d", got, want));
      end
    endtask

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BTN_W-1:0]     button_index = '0;
  logic                 raw_pressed = 1'b0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [EVENT_W-1:0]   press_event;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  press_scoreboard sb = new();

  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                sent_cnt = 0;
  logic [TIME_W-1:0] t_now = '0;

  button_debounce_press_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_index (button_index),
    .raw_pressed  (raw_pressed),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .press_event  (press_event),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // everything is settled at the falling edge; a transfer happens at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_event(press_event);
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // called at a rising edge; returns at the rising edge of the transfer
  task automatic push(input logic [BTN_W-1:0] b, input logic r, input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_index <= b;
    raw_pressed  <= r;
    now_ms       <= t;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_sample(b, r, t);
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // time step between samples, biased toward the debounce and long-press thresholds
  function automatic logic [TIME_W-1:0] pick_dt();
    logic [TIME_W-1:0] deb;
    logic [TIME_W-1:0] lp;
    deb = TIME_W'(sb.db_time);
    lp  = TIME_W'(sb.long_ms);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return (deb == 0) ? '0 : deb - 1;
      3: return deb;
      4: return deb + 1;
      5: return (lp == 0) ? '0 : lp - 1;
      6: return lp;
      7: return lp + 1;
      default: return $urandom_range(0, deb / 4 + lp / 4 + 2);
    endcase
  endfunction

  // steady samples at one level, with the other button cutting in now and then
  task automatic hold_level(input logic [BTN_W-1:0] b, input logic lvl);
    int n;
    n = $urandom_range(2, 6);
    repeat (n) begin
      t_now += pick_dt();
      push(b, lvl, t_now);
      if ($urandom_range(0, 99) < 15) push(~b, 1'($urandom_range(0, 1)), t_now);
    end
  endtask

  task automatic bounce_to(input logic [BTN_W-1:0] b, input logic lvl);
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      t_now += $urandom_range(0, 3);
      push(b, lvl ^ ((n - i) % 2 == 0), t_now);
    end
    t_now += $urandom_range(0, 3);
    push(b, lvl, t_now);
  endtask

  task automatic run_items(input int n);
    int               target;
    logic [BTN_W-1:0] b;
    target = sent_cnt + n;
    while (sent_cnt < target) begin
      b = BTN_W'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: t_now += $urandom;
          1: t_now -= $urandom_range(1, sb.db_time + 2);
          2: t_now = $urandom;
          default: t_now += pick_dt();
        endcase
        push(b, 1'($urandom_range(0, 1)), t_now);
      end else begin
        bounce_to(b, 1'b1);
        hold_level(b, 1'b1);
        bounce_to(b, 1'b0);
        hold_level(b, 1'b0);
      end
    end
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 81; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 81; end
      default: begin send_idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  logic [CFG_W-1:0] deb_set [8];
  logic [CFG_W-1:0] lp_set [8];

  initial begin
    deb_set = '{16'd50, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd20, 16'd0, 16'd50};
    lp_set  = '{16'd1500, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd300, 16'd0, 16'd1500};
    deb_set[6] = CFG_W'($urandom_range(1, 200));
    lp_set[6]  = CFG_W'($urandom_range(1, 3000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, debounce edges, long press, wrap and backward time
    push(0, 1, 32'd100);
    push(0, 1, 32'd149);
    push(0, 1, 32'd150);
    push(1, 1, 32'd160);
    push(0, 1, 32'd1649);
    push(0, 1, 32'd1650);
    push(0, 1, 32'd1700);
    push(1, 1, 32'd210);
    push(0, 0, 32'd1710);
    push(0, 0, 32'd1760);
    push(1, 0, 32'd300);
    push(1, 0, 32'd200);
    push(1, 0, 32'd350);
    push(0, 1, 32'hFFFF_FFF0);
    push(0, 1, 32'h0000_0022);
    push(0, 0, 32'h7FFF_FFFF);
    push(0, 0, 32'hFFFF_FFFF);
    push(0, 0, 32'h8000_0031);
    push(1, 1, 32'hFFFF_FFFF);
    push(1, 1, 32'h0000_0031);
    push(1, 0, 32'h0000_0000);
    push(1, 0, 32'h0000_0040);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph != 0) begin
        write_reg(REG_DEBOUNCE, deb_set[ph]);
        write_reg(REG_LONG_PRESS, lp_set[ph]);
      end
      set_mode(ph % 4);
      t_now = $urandom;
      if (ph == 1) begin
        // sender holds off mid-phase until every event is back
        run_items(60);
        drain();
        run_items(60);
      end else begin
        run_items(120);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d events never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
